// ----- rtl/tlf_pkg.sv -----
// shared types and character constants for the text line filter
package tlf_pkg;

  localparam logic [7:0] CH_LT  = 8'd60;
  localparam logic [7:0] CH_GT  = 8'd62;
  localparam logic [7:0] CH_AMP = 8'd38;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_NL  = 8'd10;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // operation picked by the front for each accepted word
  typedef enum logic [2:0] {
    OP_PASS     = 3'd0,
    OP_DROP     = 3'd1,
    OP_OS_FLUSH = 3'd2,
    OP_OS_BACK  = 3'd3,
    OP_OS_PUT   = 3'd4,
    OP_TAG_NL   = 3'd5,
    OP_TAG_BYTE = 3'd6
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  // event from the back: a byte to emit, or the end of one word's results
  typedef struct packed {
    logic       valid;
    logic       eos;
    logic [7:0] data;
    logic       ovf;
  } ev_t;

endpackage

// ----- rtl/text_line_filter.sv -----
// text line filter top level: copy, discard, overstrike and tag strip modes
// Usage:
//   input words arrive on in_valid/in_byte, held off by in_stall; results
//   leave on out_valid/out_byte/out_last_of_run/out_overflow, held by out_stall.
//   cfg_wr_en with cfg_filter_mode selects the mode; write it only while idle.
//   out_last_of_run marks the final result made by one input word; words that
//   make no result (dropped, buffered, backspace) produce nothing on the output.
// Timing:
//   a two entry queue sits between the classifier and the back sequencer.
//   copy or tag strip of a plain byte steps the back through idle, raw or
//   entity, then end; overstrike buffering and tag buffering end in idle.
//   the back sequencer sets the rate; an overstrike newline reads and emits
//   each buffered byte, and a tag released at newline or on a full buffer
//   reads and handles each buffered byte in turn.
// Reset and stall:
//   rst_n clears mode to copy and empties queue, buffer state and output.
//   the line buffer needs no clearing pass.
//   a stalled output holds its word; the queue keeps accepting until full.
module text_line_filter
  import tlf_pkg::*;
#(
  parameter int LINE_DEPTH = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_filter_mode,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_overflow
);

  localparam int CNT_W = $clog2(LINE_DEPTH + 1);

  logic             q_full;
  logic             q_push;
  cmd_t             q_in;
  cmd_t             cmd;
  logic             cmd_valid;
  logic             cmd_pop;
  ev_t              ev;
  logic             ev_ready;
  logic [CNT_W-1:0] fill_count;

  tlf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_filter_mode (cfg_filter_mode),
    .in_valid        (in_valid),
    .in_byte         (in_byte),
    .in_stall        (in_stall),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_in)
  );

  tlf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (cmd_pop),
    .pop_data  (cmd),
    .not_empty (cmd_valid)
  );

  tlf_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .ev         (ev),
    .ev_ready   (ev_ready),
    .fill_count (fill_count)
  );

  tlf_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .ev              (ev),
    .ev_ready        (ev_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_overflow    (out_overflow)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count <= CNT_W'(LINE_DEPTH))
    else $error("line buffer fill beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command taken from empty queue");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ev.valid && ev_ready))
    else $error("output word without a back event");

endmodule

// ----- rtl/tlf_ram.sv -----
// generic single write port ram with registered read
module tlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/tlf_front.sv -----
// front end: mode register, input handshake and byte classification
module tlf_front
  import tlf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_filter_mode,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_stall,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_data
);

  typedef enum logic [1:0] {
    MODE_COPY       = 2'd0,
    MODE_DISCARD    = 2'd1,
    MODE_OVERSTRIKE = 2'd2,
    MODE_TAG        = 2'd3
  } mode_t;

  mode_t mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_COPY;
    end else if (cfg_wr_en) begin
      mode_r <= mode_t'(cfg_filter_mode);
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.data = in_byte;
    case (mode_r)
      MODE_COPY: begin
        q_data.op = OP_PASS;
      end
      MODE_DISCARD: begin
        q_data.op = OP_DROP;
      end
      MODE_OVERSTRIKE: begin
        if (in_byte == CH_NL) begin
          q_data.op = OP_OS_FLUSH;
        end else if (in_byte == CH_BS) begin
          q_data.op = OP_OS_BACK;
        end else begin
          q_data.op = OP_OS_PUT;
        end
      end
      MODE_TAG: begin
        q_data.op = (in_byte == CH_NL) ? OP_TAG_NL : OP_TAG_BYTE;
      end
      default: begin
        q_data.op = OP_PASS;
      end
    endcase
  end

endmodule

// ----- rtl/tlf_queue.sv -----
// short command queue between front and back
module tlf_queue
  import tlf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic not_empty
);

  cmd_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    logic [Q_PTR_W-1:0] r;
    if (p == Q_PTR_W'(Q_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + Q_PTR_W'(1);
    end
    return r;
  endfunction

  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + Q_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/tlf_back.sv -----
// back end: line buffer, tag and entity state, result sequencing
module tlf_back
  import tlf_pkg::*;
#(
  parameter int LINE_DEPTH = 63
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  input  cmd_t                              cmd,
  output logic                              cmd_pop,
  output ev_t                               ev,
  input  logic                              ev_ready,
  output logic [$clog2(LINE_DEPTH+1)-1:0]   fill_count
);

  localparam int IDX_W = $clog2(LINE_DEPTH);
  localparam int CNT_W = $clog2(LINE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LINE_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_RAW     = 7'b0000010,
    S_OS_RD   = 7'b0000100,
    S_OS_EMIT = 7'b0001000,
    S_RL_RD   = 7'b0010000,
    S_ENT     = 7'b0100000,
    S_END     = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    ENT_NONE = 2'd0,
    ENT_AMP  = 2'd1,
    ENT_SKIP = 2'd2
  } ent_t;

  function automatic logic is_lower(input logic [7:0] b);
    return (b >= 8'd97) && (b <= 8'd122);
  endfunction

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             tag_r, tag_nxt;
  ent_t             ent_r, ent_nxt;
  logic             ovf_r, ovf_nxt;
  logic [7:0]       eb_r, eb_nxt;
  logic             lit_r, lit_nxt;
  logic             nl_r, nl_nxt;
  logic             rls_r, rls_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [7:0]       rd_data;

  logic [7:0]       src_byte;
  logic             src_lit;
  logic             ent_done;

  tlf_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // during a tag release the byte comes from the buffer and '<' is literal
  assign src_byte   = rls_r ? rd_data : eb_r;
  assign src_lit    = rls_r || lit_r;
  assign fill_count = fill_r;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    tag_nxt   = tag_r;
    ent_nxt   = ent_r;
    ovf_nxt   = ovf_r;
    eb_nxt    = eb_r;
    lit_nxt   = lit_r;
    nl_nxt    = nl_r;
    rls_nxt   = rls_r;
    cmd_pop   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = fill_r[IDX_W-1:0];
    ram_wdata = cmd.data;
    ev.valid  = 1'b0;
    ev.eos    = 1'b0;
    ev.data   = src_byte;
    ev.ovf    = ovf_r;
    ent_done  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          eb_nxt  = cmd.data;
          lit_nxt = 1'b0;
          nl_nxt  = (cmd.data == CH_NL);
          idx_nxt = '0;
          rls_nxt = 1'b0;
          case (cmd.op)
            OP_PASS: begin
              state_nxt = S_RAW;
            end
            OP_DROP: begin
              state_nxt = S_END;
            end
            OP_OS_FLUSH: begin
              state_nxt = S_OS_RD;
            end
            OP_OS_BACK: begin
              if (fill_r != '0) begin
                fill_nxt = fill_r - CNT_W'(1);
              end
            end
            OP_OS_PUT: begin
              if (fill_r < DEPTH_C) begin
                ram_we   = 1'b1;
                fill_nxt = fill_r + CNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_TAG_NL: begin
              lit_nxt   = 1'b1;
              state_nxt = tag_r ? S_RL_RD : S_ENT;
            end
            OP_TAG_BYTE: begin
              if (!tag_r) begin
                state_nxt = S_ENT;
              end else if (cmd.data == CH_GT) begin
                tag_nxt  = 1'b0;
                fill_nxt = '0;
              end else if (fill_r < DEPTH_C) begin
                ram_we   = 1'b1;
                fill_nxt = fill_r + CNT_W'(1);
              end else begin
                // buffer full: give up on the tag, then handle this byte
                ovf_nxt   = 1'b1;
                state_nxt = S_RL_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RAW: begin
        ev.valid = 1'b1;
        ev.data  = eb_r;
        if (ev_ready) begin
          state_nxt = S_END;
        end
      end
      S_OS_RD: begin
        state_nxt = (idx_r == fill_r) ? S_RAW : S_OS_EMIT;
      end
      S_OS_EMIT: begin
        ev.valid = 1'b1;
        ev.data  = rd_data;
        if (ev_ready) begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_OS_RD;
        end
      end
      S_RL_RD: begin
        if (idx_r == fill_r) begin
          tag_nxt  = 1'b0;
          fill_nxt = '0;
          rls_nxt  = 1'b0;
        end else begin
          rls_nxt = 1'b1;
        end
        state_nxt = S_ENT;
      end
      S_ENT: begin
        if (ent_r != ENT_NONE) begin
          if (is_lower(src_byte)) begin
            ent_nxt  = ENT_SKIP;
            ent_done = 1'b1;
          end else if (ent_r == ENT_AMP) begin
            // held ampersand goes out first, byte is retried next cycle
            ev.valid = 1'b1;
            ev.data  = CH_AMP;
            if (ev_ready) begin
              ent_nxt = ENT_NONE;
            end
          end else begin
            ent_nxt = ENT_NONE;
          end
        end else if (src_byte == CH_AMP) begin
          ent_nxt  = ENT_AMP;
          ent_done = 1'b1;
        end else if (src_byte == CH_LT && !src_lit) begin
          tag_nxt   = 1'b1;
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = CH_LT;
          fill_nxt  = CNT_W'(1);
          ent_done  = 1'b1;
        end else begin
          ev.valid = 1'b1;
          ev.data  = src_byte;
          ent_done = ev_ready;
        end
        if (ent_done) begin
          if (rls_r) begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = S_RL_RD;
          end else begin
            state_nxt = S_END;
          end
        end
      end
      S_END: begin
        ev.valid = 1'b1;
        ev.eos   = 1'b1;
        if (ev_ready) begin
          if (nl_r) begin
            fill_nxt = '0;
            tag_nxt  = 1'b0;
            ent_nxt  = ENT_NONE;
            ovf_nxt  = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      tag_r   <= 1'b0;
      ent_r   <= ENT_NONE;
      ovf_r   <= 1'b0;
      rls_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      tag_r   <= tag_nxt;
      ent_r   <= ent_nxt;
      ovf_r   <= ovf_nxt;
      rls_r   <= rls_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    eb_r  <= eb_nxt;
    lit_r <= lit_nxt;
    nl_r  <= nl_nxt;
  end

endmodule

// ----- rtl/tlf_out.sv -----
// output stage: holds one byte back to mark the last result of a word
module tlf_out
  import tlf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  ev_t        ev,
  output logic       ev_ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_overflow
);

  logic       hold_v_r;
  logic [7:0] hold_data_r;
  logic       hold_ovf_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_ovf_r;

  logic out_free;
  logic ev_take;
  logic push;

  assign out_free = !out_valid_r || !out_stall;
  assign ev_ready = !hold_v_r || out_free;
  assign ev_take  = ev.valid && ev_ready;
  // a held byte moves on when another byte or the end marker arrives
  assign push     = ev.valid && hold_v_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= push;
      end
      if (ev_take) begin
        hold_v_r <= !ev.eos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_byte_r <= hold_data_r;
      out_last_r <= ev.eos;
      out_ovf_r  <= hold_ovf_r;
    end
    if (ev_take && !ev.eos) begin
      hold_data_r <= ev.data;
      hold_ovf_r  <= ev.ovf;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_overflow    = out_ovf_r;

endmodule
